@@ hdl/wrts_pkg.sv @@
package wrts_pkg;

  localparam int unsigned RELAY_COUNT_DEF      = 8;
  localparam int unsigned EVENTS_PER_RELAY_DEF = 8;

  // Output masks carry at most eight relays
  localparam int unsigned MASK_BITS = 8;

  localparam int unsigned SEC_W = 17;

  localparam logic [SEC_W-1:0] SEC_PER_HOUR = 17'd3600;
  localparam logic [SEC_W-1:0] SEC_PER_MIN  = 17'd60;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] STAT_TICK  = 2'd0;
  localparam logic [1:0] STAT_ADDED = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam logic [1:0] CFG_MANUAL = 2'd0;
  localparam logic [1:0] CFG_WAVE   = 2'd1;
  localparam logic [1:0] CFG_MODES  = 2'd2;

  localparam logic [2:0] WAVE_ALWAYS  = 3'd0;
  localparam logic [2:0] WAVE_MIN_15  = 3'd1;
  localparam logic [2:0] WAVE_MIN_30  = 3'd2;
  localparam logic [2:0] WAVE_HR_ODD  = 3'd3;
  localparam logic [2:0] WAVE_HR_6    = 3'd4;
  localparam logic [2:0] WAVE_HR_12   = 3'd5;
  localparam logic [2:0] WAVE_SEC_10  = 3'd6;
  localparam logic [2:0] WAVE_OFF     = 3'd7;

  typedef struct packed {
    logic [2:0]       day;
    logic [SEC_W-1:0] on_sec;
    logic [SEC_W-1:0] off_sec;
  } event_t;

  function automatic logic [SEC_W-1:0] secs_of_day(input logic [4:0] h,
                                                   input logic [5:0] m,
                                                   input logic [5:0] s);
    return SEC_W'(h) * SEC_PER_HOUR + SEC_W'(m) * SEC_PER_MIN + SEC_W'(s);
  endfunction

  // Modulo terms unrolled over the full field range (hour < 32, min/sec < 64)
  function automatic logic wave_on(input logic [2:0] mode,
                                   input logic [4:0] h,
                                   input logic [5:0] m,
                                   input logic [5:0] s);
    logic on;
    unique case (mode)
      WAVE_ALWAYS: on = 1'b1;
      WAVE_MIN_15: on = (m < 6'd15) || (m >= 6'd30 && m < 6'd45) || (m >= 6'd60);
      WAVE_MIN_30: on = (m < 6'd30) || (m >= 6'd60);
      WAVE_HR_ODD: on = !h[0];
      WAVE_HR_6:   on = (h < 5'd6) || (h >= 5'd12 && h < 5'd18) ||
                        (h >= 5'd24 && h < 5'd30);
      WAVE_HR_12:  on = (h < 5'd12) || (h >= 5'd24);
      WAVE_SEC_10: on = (s < 6'd10) || (s >= 6'd20 && s < 6'd30) ||
                        (s >= 6'd40 && s < 6'd50) || (s >= 6'd60);
      WAVE_OFF:    on = 1'b0;
      default:     on = 1'b0;
    endcase
    return on;
  endfunction

endpackage

@@ hdl/wrts_event_mem.sv @@
module wrts_event_mem #(
  parameter int unsigned ADDR_W = 6
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [ADDR_W-1:0]     waddr_i,
  input  wrts_pkg::event_t      wdata_i,
  input  logic                  re_i,
  input  logic [ADDR_W-1:0]     raddr_i,
  output wrts_pkg::event_t      rdata_o
);
  import wrts_pkg::*;

  localparam int unsigned DEPTH = 2 ** ADDR_W;

  event_t mem_q [DEPTH];
  event_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/wrts_match.sv @@
module wrts_match (
  input  wrts_pkg::event_t            ev_i,
  input  logic [2:0]                  day_i,
  input  logic [wrts_pkg::SEC_W-1:0]  now_i,
  output logic                        hit_o
);
  import wrts_pkg::*;

  logic day_ok;
  logic covers;

  assign day_ok = (ev_i.day == 3'd0) || (ev_i.day == day_i);

  always_comb begin
    priority if (ev_i.on_sec < ev_i.off_sec) begin
      covers = (now_i >= ev_i.on_sec) && (now_i < ev_i.off_sec);
    end else if (ev_i.on_sec > ev_i.off_sec) begin
      // wraps past midnight
      covers = (now_i >= ev_i.on_sec) || (now_i < ev_i.off_sec);
    end else begin
      covers = 1'b1;
    end
  end

  assign hit_o = day_ok && covers;

endmodule

@@ hdl/weekly_relay_time_scheduler_core.sv @@
// Weekly relay scheduler. Raise start_i while busy_o is low to hand in an item; exactly one
// result follows on done_o for one cycle and must be taken then, since the block cannot be
// held off. An add is written in the S_ADD state. A tick walks relays one at a time: manual
// and wavemaker relays are settled in S_RELAY alone, a scheduled relay with stored events
// goes on to S_SCAN and reads them one by one (stopping at the first match). The scan is
// bounded by the single read port of the event memory, one event compared per cycle. Only
// relays 0..7 are visible in the masks.
module weekly_relay_time_scheduler_core #(
  parameter int unsigned RELAY_COUNT      = wrts_pkg::RELAY_COUNT_DEF,
  parameter int unsigned EVENTS_PER_RELAY = wrts_pkg::EVENTS_PER_RELAY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        opcode_i,
  input  logic [2:0]  relay_i,
  input  logic [2:0]  day_i,
  input  logic [4:0]  hour_a_i,
  input  logic [5:0]  minute_a_i,
  input  logic [5:0]  second_a_i,
  input  logic [4:0]  hour_b_i,
  input  logic [5:0]  minute_b_i,
  input  logic [5:0]  second_b_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [7:0]  relay_on_mask_o,
  output logic [7:0]  driven_mask_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i
);
  import wrts_pkg::*;

  localparam int unsigned NR     = (RELAY_COUNT < MASK_BITS) ? RELAY_COUNT : MASK_BITS;
  localparam int unsigned RW     = (NR > 1) ? $clog2(NR) : 1;
  localparam int unsigned EW     = (EVENTS_PER_RELAY > 1) ? $clog2(EVENTS_PER_RELAY) : 1;
  localparam int unsigned CW     = $clog2(EVENTS_PER_RELAY + 1);
  localparam int unsigned NSLOT  = 2 ** RW;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ADD   = 2'd1;
  localparam logic [1:0] S_RELAY = 2'd2;
  localparam logic [1:0] S_SCAN  = 2'd3;

  logic [1:0] state_q, state_d;

  // latched item
  logic             op_q;
  logic [2:0]       relay_q, day_q;
  logic [4:0]       hour_q;
  logic [5:0]       min_q, sec_q;
  logic [SEC_W-1:0] sec_a_q, sec_b_q;

  logic [7:0]  manual_q, wave_q;
  logic [23:0] modes_q;

  logic [CW-1:0] cnt_q [NSLOT];
  logic [CW-1:0] cnt_d [NSLOT];

  logic [RW-1:0] r_q, r_d;
  logic [EW:0]   j_q, j_d;
  logic          pend_q, pend_d;
  logic [7:0]    on_q, on_d, drv_q, drv_d;

  logic       done_q, done_d;
  logic [1:0] status_q, status_d;
  logic [7:0] res_on_q, res_on_d, res_drv_q, res_drv_d;

  logic [RW-1:0] cnt_sel;
  logic [CW-1:0] cur_cnt;
  logic          relay_ok, issue, hit, relay_end, last_relay;
  logic          mem_we, mem_re;
  event_t        wr_ev, rd_ev;
  logic [4:0]    mode_base;

  assign busy_o     = (state_q != S_IDLE);
  assign cnt_sel    = (state_q == S_ADD) ? relay_q[RW-1:0] : r_q;
  assign cur_cnt    = cnt_q[cnt_sel];
  assign relay_ok   = ({1'b0, relay_q} < 4'(NR));
  assign issue      = (j_q < (EW+1)'(cur_cnt));
  assign last_relay = (r_q == RW'(NR - 1));
  assign mode_base  = 5'(r_q) * 5'd3;
  assign wr_ev      = '{day: day_q, on_sec: sec_a_q, off_sec: sec_b_q};

  wrts_event_mem #(
    .ADDR_W (RW + EW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i ({relay_q[RW-1:0], cur_cnt[EW-1:0]}),
    .wdata_i (wr_ev),
    .re_i    (mem_re),
    .raddr_i ({r_q, j_q[EW-1:0]}),
    .rdata_o (rd_ev)
  );

  // sec_a_q holds the current time on a tick
  wrts_match u_match (
    .ev_i  (rd_ev),
    .day_i (day_q),
    .now_i (sec_a_q),
    .hit_o (hit)
  );

  always_comb begin
    state_d   = state_q;
    r_d       = r_q;
    j_d       = j_q;
    pend_d    = 1'b0;
    on_d      = on_q;
    drv_d     = drv_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    status_d  = status_q;
    res_on_d  = res_on_q;
    res_drv_d = res_drv_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    relay_end = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = (opcode_i == OP_ADD) ? S_ADD : S_RELAY;
          r_d     = '0;
          on_d    = '0;
          drv_d   = '0;
        end
      end
      S_ADD: begin
        status_d = STAT_FULL;
        if (relay_ok && (cur_cnt < CW'(EVENTS_PER_RELAY))) begin
          mem_we           = 1'b1;
          cnt_d[cnt_sel]   = cur_cnt + CW'(1);
          status_d         = STAT_ADDED;
        end
        res_on_d  = '0;
        res_drv_d = '0;
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end
      S_RELAY: begin
        j_d = '0;
        if (manual_q[r_q]) begin
          relay_end = 1'b1;
        end else if (wave_q[r_q]) begin
          drv_d[r_q] = 1'b1;
          on_d[r_q]  = wave_on(modes_q[mode_base +: 3], hour_q, min_q, sec_q);
          relay_end  = 1'b1;
        end else begin
          drv_d[r_q] = 1'b1;
          if (cur_cnt == '0) begin
            relay_end = 1'b1;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // reads are issued one ahead of the compare; a stale one is dropped
        if (pend_q && hit) begin
          on_d[r_q] = 1'b1;
          relay_end = 1'b1;
        end else if (issue) begin
          mem_re = 1'b1;
          j_d    = j_q + (EW+1)'(1);
          pend_d = 1'b1;
        end else begin
          relay_end = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (relay_end) begin
      if (last_relay) begin
        res_on_d  = on_d;
        res_drv_d = drv_d;
        status_d  = STAT_TICK;
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end else begin
        r_d     = r_q + RW'(1);
        state_d = S_RELAY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      r_q     <= '0;
      j_q     <= '0;
      pend_q  <= 1'b0;
      on_q    <= '0;
      drv_q   <= '0;
      done_q  <= 1'b0;
      cnt_q   <= '{default: '0};
      manual_q <= '0;
      wave_q   <= '0;
      modes_q  <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      j_q     <= j_d;
      pend_q  <= pend_d;
      on_q    <= on_d;
      drv_q   <= drv_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MANUAL: manual_q <= cfg_wdata_i[7:0];
          CFG_WAVE:   wave_q   <= cfg_wdata_i[7:0];
          CFG_MODES:  modes_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      op_q    <= opcode_i;
      relay_q <= relay_i;
      day_q   <= day_i;
      hour_q  <= hour_a_i;
      min_q   <= minute_a_i;
      sec_q   <= second_a_i;
      sec_a_q <= secs_of_day(hour_a_i, minute_a_i, second_a_i);
      sec_b_q <= secs_of_day(hour_b_i, minute_b_i, second_b_i);
    end
    status_q  <= status_d;
    res_on_q  <= res_on_d;
    res_drv_q <= res_drv_d;
  end

  // op_q is used only here: state is steered by opcode_i; op_q forces STAT_TICK for ticks
  assign done_o          = done_q;
  assign status_o        = (op_q == OP_TICK) ? STAT_TICK : status_q;
  assign relay_on_mask_o = res_on_q;
  assign driven_mask_o   = res_drv_q;

endmodule

@@ hdl/wrts_checker.sv @@
module wrts_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input logic [1:0] status_o,
  input logic [7:0] relay_on_mask_o,
  input logic [7:0] driven_mask_o
);
  import wrts_pkg::*;

  // every accepted item raises busy_o in the following cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while still busy");

  a_fell_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("item finished without a result");

  a_on_driven: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((relay_on_mask_o & ~driven_mask_o) == 8'd0))
    else $error("relay on but not driven");

  a_add_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STAT_TICK) |->
      (relay_on_mask_o == 8'd0 && driven_mask_o == 8'd0 &&
       (status_o == STAT_ADDED || status_o == STAT_FULL)))
    else $error("bad add result");

endmodule

bind weekly_relay_time_scheduler_core wrts_checker u_wrts_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .done_o          (done_o),
  .status_o        (status_o),
  .relay_on_mask_o (relay_on_mask_o),
  .driven_mask_o   (driven_mask_o)
);

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import wrts_pkg::*;

  localparam int RELAY_SLOTS     = RELAY_COUNT_DEF;
  localparam int LIST_DEPTH      = EVENTS_PER_RELAY_DEF;
  localparam int IDLE_LIMIT      = 2000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 105;

  typedef struct {
    logic       opcode;
    logic [2:0] relay;
    logic [2:0] day;
    logic [4:0] hour_a;
    logic [5:0] minute_a;
    logic [5:0] second_a;
    logic [4:0] hour_b;
    logic [5:0] minute_b;
    logic [5:0] second_b;
  } sched_item_t;

  typedef struct {
    logic [1:0] status;
    logic [7:0] on_mask;
    logic [7:0] driven;
  } relay_verdict_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start_i     = 1'b0;
  logic        busy_o;
  logic        opcode_i    = 1'b0;
  logic [2:0]  relay_i     = '0;
  logic [2:0]  day_i       = '0;
  logic [4:0]  hour_a_i    = '0;
  logic [5:0]  minute_a_i  = '0;
  logic [5:0]  second_a_i  = '0;
  logic [4:0]  hour_b_i    = '0;
  logic [5:0]  minute_b_i  = '0;
  logic [5:0]  second_b_i  = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [7:0]  relay_on_mask_o;
  logic [7:0]  driven_mask_o;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = '0;
  logic [23:0] cfg_wdata_i = '0;

  always #2 clk_i = ~clk_i;

  weekly_relay_time_scheduler_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .relay_i        (relay_i),
    .day_i          (day_i),
    .hour_a_i       (hour_a_i),
    .minute_a_i     (minute_a_i),
    .second_a_i     (second_a_i),
    .hour_b_i       (hour_b_i),
    .minute_b_i     (minute_b_i),
    .second_b_i     (second_b_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .relay_on_mask_o(relay_on_mask_o),
    .driven_mask_o  (driven_mask_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // Shadow copy of the event lists and control registers
  logic [2:0]  evt_day     [RELAY_SLOTS][LIST_DEPTH];
  int unsigned evt_on_sec  [RELAY_SLOTS][LIST_DEPTH];
  int unsigned evt_off_sec [RELAY_SLOTS][LIST_DEPTH];
  int unsigned evt_count   [RELAY_SLOTS] = '{default: 0};
  logic [7:0]  manual_bits = '0;
  logic [7:0]  wave_bits   = '0;
  logic [23:0] wave_modes  = '0;

  relay_verdict_t pending_verdicts[$];
  relay_verdict_t want;
  sched_item_t    seen_item;

  int  mismatches  = 0;
  int  idle_cycles = 0;
  int  n_adds      = 0;
  int  n_rejected  = 0;
  int  n_ticks     = 0;
  int  n_checked   = 0;
  int  n_settings  = 0;
  bit  quiet;
  bit  no_idle     = 1'b0;

  function automatic int unsigned day_secs(logic [4:0] h, logic [5:0] m, logic [5:0] s);
    return h * 3600 + m * 60 + s;
  endfunction

  function automatic bit window_hit(int unsigned on_s, int unsigned off_s, int unsigned now);
    if (on_s < off_s) return now >= on_s && now < off_s;
    if (on_s > off_s) return now >= on_s || now < off_s;
    return 1'b1;
  endfunction

  function automatic bit wave_pattern(logic [2:0] mode, logic [4:0] h, logic [5:0] m,
                                      logic [5:0] s);
    case (mode)
      WAVE_ALWAYS: return 1'b1;
      WAVE_MIN_15: return (m % 30) < 15;
      WAVE_MIN_30: return (m % 60) < 30;
      WAVE_HR_ODD: return (h % 2) == 0;
      WAVE_HR_6:   return (h % 12) < 6;
      WAVE_HR_12:  return (h % 24) < 12;
      WAVE_SEC_10: return (s % 20) < 10;
      default:     return 1'b0;
    endcase
  endfunction

  // Applies one accepted item to the shadow state and returns its result
  function automatic relay_verdict_t predict_verdict(sched_item_t it);
    relay_verdict_t v;
    int unsigned    now;
    int unsigned    slot;
    bit             on;
    v.status  = STAT_TICK;
    v.on_mask = '0;
    v.driven  = '0;
    if (it.opcode == OP_ADD) begin
      v.status = STAT_FULL;
      if (it.relay < RELAY_SLOTS && evt_count[it.relay] < LIST_DEPTH) begin
        slot = evt_count[it.relay];
        evt_day[it.relay][slot]     = it.day;
        evt_on_sec[it.relay][slot]  = day_secs(it.hour_a, it.minute_a, it.second_a);
        evt_off_sec[it.relay][slot] = day_secs(it.hour_b, it.minute_b, it.second_b);
        evt_count[it.relay]++;
        v.status = STAT_ADDED;
      end
      return v;
    end
    now = day_secs(it.hour_a, it.minute_a, it.second_a);
    for (int r = 0; r < RELAY_SLOTS && r < 8; r++) begin
      if (!manual_bits[r]) begin
        on = 1'b0;
        if (wave_bits[r]) begin
          on = wave_pattern(wave_modes[3*r +: 3], it.hour_a, it.minute_a, it.second_a);
        end else begin
          for (int j = 0; j < evt_count[r]; j++) begin
            if ((evt_day[r][j] == 0 || evt_day[r][j] == it.day) &&
                window_hit(evt_on_sec[r][j], evt_off_sec[r][j], now)) begin
              on = 1'b1;
            end
          end
        end
        v.driven[r]  = 1'b1;
        v.on_mask[r] = on;
      end
    end
    return v;
  endfunction

  function automatic void check_field(string what, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, what, exp_val, act_val);
    end
  endfunction

  // Result checking, item capture, register shadowing and the watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet = 1'b1;
      if (done_o) begin
        quiet = 1'b0;
        if (pending_verdicts.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result status %0d on_mask %h driven %h", $time,
                   status_o, relay_on_mask_o, driven_mask_o);
        end else begin
          want = pending_verdicts.pop_front();
          check_field("status", want.status, status_o);
          check_field("relay_on_mask", want.on_mask, relay_on_mask_o);
          check_field("driven_mask", want.driven, driven_mask_o);
          n_checked++;
        end
      end
      if (start_i && !busy_o) begin
        quiet              = 1'b0;
        seen_item.opcode   = opcode_i;
        seen_item.relay    = relay_i;
        seen_item.day      = day_i;
        seen_item.hour_a   = hour_a_i;
        seen_item.minute_a = minute_a_i;
        seen_item.second_a = second_a_i;
        seen_item.hour_b   = hour_b_i;
        seen_item.minute_b = minute_b_i;
        seen_item.second_b = second_b_i;
        want = predict_verdict(seen_item);
        pending_verdicts.push_back(want);
        if (opcode_i == OP_TICK) n_ticks++;
        else n_adds++;
        if (want.status == STAT_FULL) n_rejected++;
      end
      if (cfg_we_i) begin
        quiet = 1'b0;
        case (cfg_idx_i)
          CFG_MANUAL: manual_bits = cfg_wdata_i[7:0];
          CFG_WAVE:   wave_bits   = cfg_wdata_i[7:0];
          CFG_MODES:  wave_modes  = cfg_wdata_i;
          default: ;
        endcase
      end
      idle_cycles = quiet ? idle_cycles + 1 : 0;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
                 IDLE_LIMIT, pending_verdicts.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic sched_item_t make_item(logic op, logic [2:0] relay, logic [2:0] day,
                                            logic [4:0] ha, logic [5:0] ma, logic [5:0] sa,
                                            logic [4:0] hb, logic [5:0] mb, logic [5:0] sb);
    sched_item_t it;
    it.opcode   = op;
    it.relay    = relay;
    it.day      = day;
    it.hour_a   = ha;
    it.minute_a = ma;
    it.second_a = sa;
    it.hour_b   = hb;
    it.minute_b = mb;
    it.second_b = sb;
    return it;
  endfunction

  // Mostly legal clock values, now and then anything the field holds
  function automatic logic [4:0] rand_hour();
    if ($urandom_range(0, 9) == 0) return 5'($urandom_range(0, 31));
    return 5'($urandom_range(0, 23));
  endfunction

  function automatic logic [5:0] rand_min_sec();
    if ($urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, 59));
  endfunction

  function automatic sched_item_t rand_item(int add_pct);
    logic op;
    op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_TICK;
    return make_item(op, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                     rand_hour(), rand_min_sec(), rand_min_sec(),
                     rand_hour(), rand_min_sec(), rand_min_sec());
  endfunction

  task automatic send_item(sched_item_t it);
    int gap;
    opcode_i   <= it.opcode;
    relay_i    <= it.relay;
    day_i      <= it.day;
    hour_a_i   <= it.hour_a;
    minute_a_i <= it.minute_a;
    second_a_i <= it.second_a;
    hour_b_i   <= it.hour_b;
    minute_b_i <= it.minute_b;
    second_b_i <= it.second_b;
    start_i    <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Only called with the block idle
  task automatic set_config(logic [7:0] manual, logic [7:0] wave, logic [23:0] modes);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_MANUAL;
    cfg_wdata_i <= {16'd0, manual};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_WAVE;
    cfg_wdata_i <= {16'd0, wave};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_MODES;
    cfg_wdata_i <= modes;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    n_settings++;
  endtask

  task automatic test_schedule_directed();
    // empty lists: every relay driven and off
    send_item(make_item(OP_TICK, 0, 1, 0, 0, 0, 0, 0, 0));
    // wraps past midnight, every day
    send_item(make_item(OP_ADD, 0, 0, 22, 0, 0, 2, 0, 0));
    // equal on and off: all day on day 3
    send_item(make_item(OP_ADD, 1, 3, 5, 5, 5, 5, 5, 5));
    // out-of-range on time, all field bits set
    send_item(make_item(OP_ADD, 2, 7, 31, 63, 63, 0, 0, 0));
    send_item(make_item(OP_ADD, 3, 0, 0, 0, 0, 23, 59, 59));
    // fill relay 7, the last add is rejected as full
    for (int i = 0; i <= LIST_DEPTH; i++) begin
      send_item(make_item(OP_ADD, 7, 3'(i), 5'(2 * i), 0, 0, 5'(2 * i + 3), 30, 0));
    end
    // tick day 0 only matches every-day events
    send_item(make_item(OP_TICK, 0, 0, 23, 30, 0, 0, 0, 0));
    send_item(make_item(OP_TICK, 0, 3, 12, 0, 0, 0, 0, 0));
    send_item(make_item(OP_TICK, 5, 7, 31, 63, 63, 31, 63, 63));
    send_item(make_item(OP_TICK, 0, 1, 1, 59, 59, 0, 0, 0));
    send_item(make_item(OP_TICK, 0, 2, 23, 59, 59, 0, 0, 0));
    wait_drained();
  endtask

  task automatic test_wave_directed();
    // relay r runs pattern r; relays 0 and 5 manual
    set_config(8'h21, 8'hFF, {WAVE_OFF, WAVE_SEC_10, WAVE_HR_12, WAVE_HR_6,
                              WAVE_HR_ODD, WAVE_MIN_30, WAVE_MIN_15, WAVE_ALWAYS});
    send_item(make_item(OP_TICK, 0, 1, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_TICK, 0, 2, 13, 17, 25, 0, 0, 0));
    send_item(make_item(OP_TICK, 0, 7, 31, 63, 63, 0, 0, 0));
    send_item(make_item(OP_TICK, 0, 4, 6, 45, 15, 0, 0, 0));
    send_item(make_item(OP_TICK, 0, 5, 24, 59, 9, 0, 0, 0));
    send_item(make_item(OP_TICK, 0, 6, 11, 29, 59, 0, 0, 0));
    wait_drained();
  endtask

  task automatic test_random_phases();
    int add_pct;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: set_config(8'h00, 8'h00, 24'h000000);
        2: set_config(8'hFF, 8'h00, 24'hFFFFFF);
        3: set_config(8'h00, 8'hFF, 24'($urandom));
        4: set_config(8'h00, 8'hFF, 24'hFFFFFF);
        default: set_config(8'($urandom), 8'($urandom), 24'($urandom));
      endcase
      // heavy adds first so the lists fill with random windows
      add_pct = (ph == 0) ? 45 : 15;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k % 30 == 0) no_idle = ($urandom_range(0, 2) == 0);
        send_item(rand_item(add_pct));
      end
      no_idle = 1'b0;
      wait_drained();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_schedule_directed();
    test_wave_directed();
    test_random_phases();
    $display("checked %0d results: %0d adds (%0d rejected), %0d ticks, %0d register settings",
             n_checked, n_adds, n_rejected, n_ticks, n_settings);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
